// ===== hw/rtl/lik_pkg.sv =====
// ----------------------------------------------------------------------------
// lik_pkg
// Shared types, register indexes, fixed internal widths and the arctangent
// table of the leg inverse kinematics pipeline.
// ----------------------------------------------------------------------------
package lik_pkg;

    // Configuration port
    localparam int CFG_W     = 15;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_COXA_LEN  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_FEMUR_LEN = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TIBIA_LEN = 2'd2;

    localparam logic [CFG_W-1:0] COXA_LEN_RST  = 15'd1600;
    localparam logic [CFG_W-1:0] FEMUR_LEN_RST = 15'd6720;
    localparam logic [CFG_W-1:0] TIBIA_LEN_RST = 15'd6720;

    // Result status codes
    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_TOO_FAR   = 2'd1,
        ST_TOO_CLOSE = 2'd2,
        ST_RANGE     = 2'd3
    } t_status;

    // Root width of the sine-term square root (radicand is twice as wide)
    localparam int SQ2_N = 32;

    // Vectoring CORDIC: input width, datapath width, normalization bit
    localparam int CORD_IW  = 34;
    localparam int CORD_DW  = 45;
    localparam int NORM_BIT = 40;

    // Internal angles: signed, LSB is pi/2^31, range (-pi, pi]
    localparam int ANG_IW = 33;
    localparam logic signed [ANG_IW-1:0] HALF_TURN    = {2'b01, 31'd0};
    localparam logic signed [ANG_IW-1:0] QUARTER_TURN = {3'b001, 30'd0};

    localparam int ATAN_W = 30;

    // atan(2^-i) in units of pi/2^31
    function automatic logic [ATAN_W-1:0] atan_entry(input logic [4:0] idx);
        logic [ATAN_W-1:0] v;
        unique case (idx)
            5'd0:    v = 30'd536870912;
            5'd1:    v = 30'd316933406;
            5'd2:    v = 30'd167458907;
            5'd3:    v = 30'd85004756;
            5'd4:    v = 30'd42667331;
            5'd5:    v = 30'd21354465;
            5'd6:    v = 30'd10679838;
            5'd7:    v = 30'd5340245;
            5'd8:    v = 30'd2670163;
            5'd9:    v = 30'd1335087;
            5'd10:   v = 30'd667544;
            5'd11:   v = 30'd333772;
            5'd12:   v = 30'd166886;
            5'd13:   v = 30'd83443;
            5'd14:   v = 30'd41722;
            5'd15:   v = 30'd20861;
            5'd16:   v = 30'd10430;
            5'd17:   v = 30'd5215;
            5'd18:   v = 30'd2608;
            5'd19:   v = 30'd1304;
            5'd20:   v = 30'd652;
            5'd21:   v = 30'd326;
            5'd22:   v = 30'd163;
            5'd23:   v = 30'd81;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

// ===== hw/rtl/lik_sqrt.sv =====
// ----------------------------------------------------------------------------
// lik_sqrt
// Pipelined integer square root rounded to nearest: one root bit per stage,
// then a rounding stage. Takes one radicand per cycle.
// ----------------------------------------------------------------------------
module lik_sqrt #(
    parameter int N = 16
) (
    input  logic           i_clk,
    input  logic [2*N-1:0] i_radicand,
    output logic [N:0]     o_root
);

    logic [2*N-1:0] w_rad_in [N];
    logic [N+1:0]   w_rem_in [N];
    logic [N-1:0]   w_q_in   [N];

    logic [2*N-1:0] r_rad [N];
    logic [N+1:0]   r_rem [N];
    logic [N-1:0]   r_q   [N];
    logic [N:0]     r_root;

    // Feed each stage from the one before
    always_comb begin
        w_rad_in[0] = i_radicand;
        w_rem_in[0] = '0;
        w_q_in[0]   = '0;
        for (int k = 1; k < N; k++) begin
            w_rad_in[k] = r_rad[k-1];
            w_rem_in[k] = r_rem[k-1];
            w_q_in[k]   = r_q[k-1];
        end
    end

    // Decide one root bit per stage
    for (genvar k = 0; k < N; k++) begin : g_stage
        logic [N+1:0] rem_sh;
        logic [N+1:0] trial;
        logic         ge;

        always_comb begin
            rem_sh = {w_rem_in[k][N-1:0], w_rad_in[k][2*N-1 -: 2]};
            trial  = {w_q_in[k], 2'b01};
            ge     = (rem_sh >= trial);
        end

        always_ff @(posedge i_clk) begin
            r_rem[k] <= ge ? (rem_sh - trial) : rem_sh;
            r_q[k]   <= {w_q_in[k][N-2:0], ge};
            r_rad[k] <= w_rad_in[k] << 2;
        end
    end

    // Round up when the remainder exceeds the root
    always_ff @(posedge i_clk) begin
        r_root <= (N+1)'(r_q[N-1]) + (N+1)'(r_rem[N-1] > (N+2)'(r_q[N-1]));
    end

    assign o_root = r_root;

endmodule

// ===== hw/rtl/lik_cordic.sv =====
// ----------------------------------------------------------------------------
// lik_cordic
// Pipelined vectoring CORDIC atan2(y, x): half-plane fold, normalization to
// a fixed magnitude, one rotation per stage.
// ----------------------------------------------------------------------------
module lik_cordic
    import lik_pkg::*;
#(
    parameter int ITER = 16
) (
    input  logic                      i_clk,
    input  logic signed [CORD_IW-1:0] i_y,
    input  logic signed [CORD_IW-1:0] i_x,
    output logic signed [ANG_IW-1:0]  o_angle
);

    localparam int EW  = CORD_IW + 1;
    localparam int SHW = 6;
    localparam int ZW  = ANG_IW + 1;
    localparam logic signed [ZW-1:0] Z_HALF = ZW'(HALF_TURN);
    localparam logic signed [ZW-1:0] Z_TURN = Z_HALF <<< 1;

    function automatic logic [SHW-1:0] norm_shift(input logic [CORD_IW-1:0] m);
        logic [SHW-1:0] p;
        p = '0;
        for (int i = 0; i < CORD_IW; i++) begin
            if (m[i]) begin
                p = SHW'(i);
            end
        end
        return SHW'(NORM_BIT) - p;
    endfunction

    // Stage A: fold into the right half plane, catch the axis cases
    logic signed [EW-1:0]     w_x_e, w_y_e, w_xa, w_ya, w_ya_mag;
    logic [CORD_IW-1:0]       w_m;
    logic                     w_flip, w_spec;
    logic signed [ANG_IW-1:0] w_sval;

    always_comb begin
        w_x_e    = EW'(i_x);
        w_y_e    = EW'(i_y);
        w_flip   = i_x[CORD_IW-1];
        w_xa     = w_flip ? -w_x_e : w_x_e;
        w_ya     = w_flip ? -w_y_e : w_y_e;
        w_ya_mag = w_ya[EW-1] ? -w_ya : w_ya;
        w_m      = (w_xa > w_ya_mag) ? w_xa[CORD_IW-1:0] : w_ya_mag[CORD_IW-1:0];
        w_spec   = 1'b1;
        if (i_y == '0) begin
            w_sval = w_flip ? HALF_TURN : '0;
        end else if (i_x == '0) begin
            w_sval = i_y[CORD_IW-1] ? -QUARTER_TURN : QUARTER_TURN;
        end else begin
            w_spec = 1'b0;
            w_sval = '0;
        end
    end

    logic signed [EW-1:0]     r_a_x, r_a_y;
    logic [CORD_IW-1:0]       r_a_m;
    logic                     r_a_flip, r_a_spec;
    logic signed [ANG_IW-1:0] r_a_sval;

    always_ff @(posedge i_clk) begin
        r_a_x    <= w_xa;
        r_a_y    <= w_ya;
        r_a_m    <= w_m;
        r_a_flip <= w_flip;
        r_a_spec <= w_spec;
        r_a_sval <= w_sval;
    end

    // Stage B: find the shift that brings the magnitude to the norm bit
    logic signed [EW-1:0]     r_b_x, r_b_y;
    logic [SHW-1:0]           r_b_sh;
    logic                     r_b_flip, r_b_spec;
    logic signed [ANG_IW-1:0] r_b_sval;

    always_ff @(posedge i_clk) begin
        r_b_x    <= r_a_x;
        r_b_y    <= r_a_y;
        r_b_sh   <= norm_shift(r_a_m);
        r_b_flip <= r_a_flip;
        r_b_spec <= r_a_spec;
        r_b_sval <= r_a_sval;
    end

    // Stage C and rotations: entry k holds the vector before rotation k
    logic signed [CORD_DW-1:0] r_ix [ITER+1];
    logic signed [CORD_DW-1:0] r_iy [ITER+1];
    logic signed [ZW-1:0]      r_iz [ITER+1];
    logic                      r_iflip [ITER+1];
    logic                      r_ispec [ITER+1];
    logic signed [ANG_IW-1:0]  r_isval [ITER+1];

    always_ff @(posedge i_clk) begin
        r_ix[0]    <= CORD_DW'(r_b_x) <<< r_b_sh;
        r_iy[0]    <= CORD_DW'(r_b_y) <<< r_b_sh;
        r_iz[0]    <= '0;
        r_iflip[0] <= r_b_flip;
        r_ispec[0] <= r_b_spec;
        r_isval[0] <= r_b_sval;
    end

    for (genvar k = 0; k < ITER; k++) begin : g_iter
        always_ff @(posedge i_clk) begin
            if (!r_iy[k][CORD_DW-1]) begin
                r_ix[k+1] <= r_ix[k] + (r_iy[k] >>> k);
                r_iy[k+1] <= r_iy[k] - (r_ix[k] >>> k);
                r_iz[k+1] <= r_iz[k] + $signed(ZW'(atan_entry(5'(k))));
            end else begin
                r_ix[k+1] <= r_ix[k] - (r_iy[k] >>> k);
                r_iy[k+1] <= r_iy[k] + (r_ix[k] >>> k);
                r_iz[k+1] <= r_iz[k] - $signed(ZW'(atan_entry(5'(k))));
            end
            r_iflip[k+1] <= r_iflip[k];
            r_ispec[k+1] <= r_ispec[k];
            r_isval[k+1] <= r_isval[k];
        end
    end

    // Final stage: undo the fold and wrap into (-pi, pi]
    logic signed [ZW-1:0]     w_zf;
    logic signed [ANG_IW-1:0] r_out;

    always_comb begin
        w_zf = r_iz[ITER] + (r_iflip[ITER] ? Z_HALF : ZW'(0));
        if (w_zf > Z_HALF) begin
            w_zf = w_zf - Z_TURN;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out <= r_ispec[ITER] ? r_isval[ITER] : w_zf[ANG_IW-1:0];
    end

    assign o_angle = r_out;

endmodule

// ===== hw/rtl/leg_inverse_kinematics.sv =====
// ----------------------------------------------------------------------------
// leg_inverse_kinematics
// Throughput: one target per cycle; busy stays low, the pipeline never stalls.
// The pipeline depth is set mainly by the two square-root pipelines and the CORDIC stages.
// Reset clears the valid pipeline and loads the link lengths.
// ----------------------------------------------------------------------------
module leg_inverse_kinematics
    import lik_pkg::*;
#(
    parameter int COORD_WIDTH       = 16,
    parameter int ANGLE_WIDTH       = 16,
    parameter int CORDIC_ITERATIONS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic signed [COORD_WIDTH-1:0] i_target_x,
    input  logic signed [COORD_WIDTH-1:0] i_target_y,
    input  logic signed [COORD_WIDTH-1:0] i_target_z,
    input  logic                          i_cfg_we,
    input  logic [CFG_IDX_W-1:0]          i_cfg_idx,
    input  logic [CFG_W-1:0]              i_cfg_data,
    output logic                          o_done,
    output logic [1:0]                    o_status,
    output logic signed [ANGLE_WIDTH-1:0] o_coxa_out,
    output logic signed [ANGLE_WIDTH-1:0] o_femur_out,
    output logic signed [ANGLE_WIDTH-1:0] o_tibia_out
);

    localparam int CW  = COORD_WIDTH;
    localparam int AW  = ANGLE_WIDTH;
    localparam int LW  = ((CW > CFG_W) ? CW : CFG_W) + 2;
    localparam int ULW = LW - 1;
    localparam int DW  = 2 * ULW + 1;
    localparam int NW  = DW + 2;
    localparam int FW  = ANG_IW + 1;

    localparam int D_SQ1 = CW + 1;
    localparam int D_SQ2 = SQ2_N + 1;
    localparam int D_COR = CORDIC_ITERATIONS + 4;

    // Stage indexes, stage 0 is the input register
    localparam int P3  = 2 + D_SQ1;
    localparam int P4  = P3 + 1;
    localparam int P7  = P3 + 4;
    localparam int P8  = P3 + 5;
    localparam int P10 = P3 + 6 + D_SQ2;
    localparam int P12 = P10 + D_COR + 1;
    localparam int P13 = P12 + 1;
    localparam int LAT = P13 + 1;

    localparam int ANG_SH = 32 - AW;
    localparam logic signed [FW-1:0] ANG_RND  = FW'(1) <<< (ANG_SH - 1);
    localparam logic signed [FW-1:0] FW_HALF  = FW'(HALF_TURN);

    function automatic logic [AW-1:0] to_angle(input logic signed [FW-1:0] a);
        logic signed [FW-1:0] v;
        v = (a + ANG_RND) >>> ANG_SH;
        return v[AW-1:0];
    endfunction

    function automatic logic [CW-1:0] mag(input logic signed [CW-1:0] v);
        return v[CW-1] ? CW'(-v) : CW'(v);
    endfunction

    // ------------------------------------------------------------------
    // Configuration registers and terms derived from them
    // ------------------------------------------------------------------
    logic [CFG_W-1:0] r_coxa_len, r_femur_len, r_tibia_len;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coxa_len  <= COXA_LEN_RST;
            r_femur_len <= FEMUR_LEN_RST;
            r_tibia_len <= TIBIA_LEN_RST;
        end else if (i_cfg_we) begin
            if (i_cfg_idx == REG_COXA_LEN) begin
                r_coxa_len <= i_cfg_data;
            end
            if (i_cfg_idx == REG_FEMUR_LEN) begin
                r_femur_len <= i_cfg_data;
            end
            if (i_cfg_idx == REG_TIBIA_LEN) begin
                r_tibia_len <= i_cfg_data;
            end
        end
    end

    logic [29:0] r_ff, r_tt, r_dif_sq;
    logic [31:0] r_sum_sq;
    logic [30:0] r_ft2, r_ff2;
    logic [15:0] w_sum;
    logic [14:0] w_dif;

    always_comb begin
        w_sum = 16'(r_femur_len) + 16'(r_tibia_len);
        w_dif = (r_femur_len > r_tibia_len) ? (r_femur_len - r_tibia_len)
                                            : (r_tibia_len - r_femur_len);
    end

    always_ff @(posedge i_clk) begin
        r_ff     <= 30'(r_femur_len) * 30'(r_femur_len);
        r_tt     <= 30'(r_tibia_len) * 30'(r_tibia_len);
        r_sum_sq <= 32'(w_sum) * 32'(w_sum);
        r_dif_sq <= 30'(w_dif) * 30'(w_dif);
        r_ft2    <= (31'(r_femur_len) * 31'(r_tibia_len)) << 1;
        r_ff2    <= (31'(r_femur_len) * 31'(r_femur_len)) << 1;
    end

    // ------------------------------------------------------------------
    // Valid pipeline
    // ------------------------------------------------------------------
    logic r_vld [P13+1];

    assign busy = 1'b0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= P13; k++) begin
                r_vld[k] <= 1'b0;
            end
        end else begin
            r_vld[0] <= start && !busy;
            for (int k = 1; k <= P13; k++) begin
                r_vld[k] <= r_vld[k-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Target delay line, entry k holds stage k
    // ------------------------------------------------------------------
    logic [3*CW-1:0] r_xyz [P10+1];

    always_ff @(posedge i_clk) begin
        r_xyz[0] <= {i_target_x, i_target_y, i_target_z};
        for (int k = 1; k <= P10; k++) begin
            r_xyz[k] <= r_xyz[k-1];
        end
    end

    logic signed [CW-1:0] w_x0, w_y0, w_z4, w_x10, w_y10, w_z10;

    assign w_x0  = $signed(r_xyz[0][3*CW-1:2*CW]);
    assign w_y0  = $signed(r_xyz[0][2*CW-1:CW]);
    assign w_z4  = $signed(r_xyz[P4][CW-1:0]);
    assign w_x10 = $signed(r_xyz[P10][3*CW-1:2*CW]);
    assign w_y10 = $signed(r_xyz[P10][2*CW-1:CW]);
    assign w_z10 = $signed(r_xyz[P10][CW-1:0]);

    // ------------------------------------------------------------------
    // Horizontal distance: squares, sum, rounded root
    // ------------------------------------------------------------------
    logic [2*CW-1:0] r_sqx, r_sqy, r_sxy;
    logic [CW:0]     w_r;

    always_ff @(posedge i_clk) begin
        r_sqx <= (2*CW)'(mag(w_x0)) * (2*CW)'(mag(w_x0));
        r_sqy <= (2*CW)'(mag(w_y0)) * (2*CW)'(mag(w_y0));
        r_sxy <= r_sqx + r_sqy;
    end

    lik_sqrt #(
        .N (CW)
    ) u_sqrt_reach (
        .i_clk      (i_clk),
        .i_radicand (r_sxy),
        .o_root     (w_r)
    );

    // ------------------------------------------------------------------
    // Planar reach and squared target distance
    // ------------------------------------------------------------------
    logic signed [LW-1:0] r_len [P10-P4+1];
    logic [ULW-1:0]       w_ul;
    logic [2*ULW-1:0]     r_ul2;
    logic [2*CW-1:0]      r_z2;
    logic [DW-1:0]        r_d2;

    always_ff @(posedge i_clk) begin
        r_len[0] <= $signed(LW'(w_r)) - $signed(LW'(r_coxa_len));
        for (int k = 1; k <= P10 - P4; k++) begin
            r_len[k] <= r_len[k-1];
        end
    end

    assign w_ul = r_len[0][LW-1] ? ULW'(-r_len[0]) : ULW'(r_len[0]);

    always_ff @(posedge i_clk) begin
        r_ul2 <= (2*ULW)'(w_ul) * (2*ULW)'(w_ul);
        r_z2  <= (2*CW)'(mag(w_z4)) * (2*CW)'(mag(w_z4));
        r_d2  <= DW'(r_ul2) + DW'(r_z2);
    end

    // ------------------------------------------------------------------
    // Reach checks and law-of-cosines terms
    // ------------------------------------------------------------------
    logic [1:0]           r_flg [P12-P7+1];
    logic signed [NW-1:0] r_n;

    always_ff @(posedge i_clk) begin
        r_flg[0] <= {(r_d2 >= DW'(r_sum_sq)), (r_d2 <= DW'(r_dif_sq))};
        for (int k = 1; k <= P12 - P7; k++) begin
            r_flg[k] <= r_flg[k-1];
        end
        r_n <= $signed(NW'(r_d2)) - $signed(NW'(r_ff)) - $signed(NW'(r_tt));
    end

    logic signed [NW-1:0]      w_a_full, w_b_full, w_n2_full;
    logic [31:0]               r_a, r_b;
    logic signed [CORD_IW-1:0] r_nt [P10-P8+1];
    logic signed [CORD_IW-1:0] r_n2 [P10-P8+1];
    logic [2*SQ2_N-1:0]        r_s2;
    logic [SQ2_N:0]            w_st;

    always_comb begin
        w_a_full  = $signed(NW'(r_ft2)) - r_n;
        w_b_full  = $signed(NW'(r_ft2)) + r_n;
        w_n2_full = $signed(NW'(r_ff2)) + r_n;
    end

    // Hold the cosine terms alongside the sine root
    always_ff @(posedge i_clk) begin
        r_a     <= w_a_full[31:0];
        r_b     <= w_b_full[31:0];
        r_nt[0] <= r_n[CORD_IW-1:0];
        r_n2[0] <= w_n2_full[CORD_IW-1:0];
        for (int k = 1; k <= P10 - P8; k++) begin
            r_nt[k] <= r_nt[k-1];
            r_n2[k] <= r_n2[k-1];
        end
        r_s2 <= (2*SQ2_N)'(r_a) * (2*SQ2_N)'(r_b);
    end

    lik_sqrt #(
        .N (SQ2_N)
    ) u_sqrt_sine (
        .i_clk      (i_clk),
        .i_radicand (r_s2),
        .o_root     (w_st)
    );

    // ------------------------------------------------------------------
    // Four angles in parallel
    // ------------------------------------------------------------------
    logic signed [CORD_IW-1:0] w_st_s;
    logic signed [ANG_IW-1:0]  w_coxa, w_tib, w_alp, w_elev;

    assign w_st_s = $signed(CORD_IW'(w_st));

    lik_cordic #(
        .ITER (CORDIC_ITERATIONS)
    ) u_cordic_coxa (
        .i_clk   (i_clk),
        .i_y     (CORD_IW'(w_y10)),
        .i_x     (CORD_IW'(w_x10)),
        .o_angle (w_coxa)
    );

    lik_cordic #(
        .ITER (CORDIC_ITERATIONS)
    ) u_cordic_tibia (
        .i_clk   (i_clk),
        .i_y     (w_st_s),
        .i_x     (r_nt[P10-P8]),
        .o_angle (w_tib)
    );

    lik_cordic #(
        .ITER (CORDIC_ITERATIONS)
    ) u_cordic_offset (
        .i_clk   (i_clk),
        .i_y     (w_st_s),
        .i_x     (r_n2[P10-P8]),
        .o_angle (w_alp)
    );

    lik_cordic #(
        .ITER (CORDIC_ITERATIONS)
    ) u_cordic_elev (
        .i_clk   (i_clk),
        .i_y     (CORD_IW'(w_z10)),
        .i_x     (CORD_IW'(r_len[P10-P4])),
        .o_angle (w_elev)
    );

    // ------------------------------------------------------------------
    // Femur angle, status and output rounding
    // ------------------------------------------------------------------
    logic signed [FW-1:0]     r_fem;
    logic signed [ANG_IW-1:0] r_tib12, r_coxa12;

    always_ff @(posedge i_clk) begin
        r_fem    <= FW'(w_elev) - FW'(w_alp);
        r_tib12  <= w_tib;
        r_coxa12 <= w_coxa;
    end

    t_status              w_status;
    logic                 w_range;
    t_status              r_status;
    logic [AW-1:0]        r_coxa_o, r_fem_o, r_tib_o;

    always_comb begin
        w_range = (r_fem < -FW_HALF) || (r_fem > FW_HALF);
        priority if (r_flg[P12-P7][1]) begin
            w_status = ST_TOO_FAR;
        end else if (r_flg[P12-P7][0]) begin
            w_status = ST_TOO_CLOSE;
        end else if (w_range) begin
            w_status = ST_RANGE;
        end else begin
            w_status = ST_OK;
        end
    end

    always_ff @(posedge i_clk) begin
        r_status <= w_status;
        r_coxa_o <= to_angle(FW'(r_coxa12));
        r_fem_o  <= (w_status == ST_OK) ? to_angle(r_fem) : '0;
        r_tib_o  <= (w_status == ST_OK) ? to_angle(FW'(r_tib12)) : '0;
    end

    assign o_done      = r_vld[P13];
    assign o_status    = r_status;
    assign o_coxa_out  = $signed(r_coxa_o);
    assign o_femur_out = $signed(r_fem_o);
    assign o_tibia_out = $signed(r_tib_o);

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_result_follows_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |-> ##LAT o_done)
        else $error("item taken but no result after the pipeline latency");

    a_no_result_without_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(start && !busy, LAT))
        else $error("result without a matching item");

    a_fail_zero_angles: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_status != ST_OK)) |-> ((o_femur_out == '0) && (o_tibia_out == '0)))
        else $error("failed item carries nonzero femur or tibia angle");

endmodule

// ===== bench/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for leg_inverse_kinematics. Targets go in through the
// start/busy handshake with random gaps. A bit-exact joint angle predictor
// keeps a queue of expected angle sets, and every o_done strobe is checked
// against the oldest entry. Link lengths are rewritten between phases,
// extremes included.
// ----------------------------------------------------------------------------
module testbench;
    import lik_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CW        = 16;
    localparam int AW        = 16;
    localparam int ITERS     = 16;
    localparam int LATENCY   = CW + ITERS + 49;
    localparam int IDLE_LIM  = 4000;
    localparam int PHASE_LEN = 320;

    typedef struct {
        t_status      status;
        logic [AW-1:0] coxa;
        logic [AW-1:0] femur;
        logic [AW-1:0] tibia;
    } t_joint_set;

    // Joint angle predictor and store of pending angle sets
    class joint_scoreboard;
        longint     half_turn = longint'(1) << 31;
        longint     arctan[ITERS];
        bit [14:0]  coxa_len, femur_len, tibia_len;
        t_joint_set pending[$];
        int         errors;
        int         hits[4];

        function new();
            arctan = '{536870912, 316933406, 167458907, 85004756, 42667331,
                       21354465, 10679838, 5340245, 2670163, 1335087, 667544,
                       333772, 166886, 83443, 41722, 20861};
            coxa_len  = COXA_LEN_RST;
            femur_len = FEMUR_LEN_RST;
            tibia_len = TIBIA_LEN_RST;
        endfunction

        function void set_len(logic [CFG_IDX_W-1:0] idx, bit [14:0] val);
            case (idx)
                REG_COXA_LEN:  coxa_len  = val;
                REG_FEMUR_LEN: femur_len = val;
                REG_TIBIA_LEN: tibia_len = val;
                default: ;
            endcase
        endfunction

        function bit [63:0] root_floor(bit [63:0] s);
            bit [63:0] res, b;
            res = 0;
            b = 64'd1 << 62;
            while (b > s) b = b >> 2;
            while (b != 0) begin
                if (s >= res + b) begin
                    s   = s - (res + b);
                    res = (res >> 1) + b;
                end else begin
                    res = res >> 1;
                end
                b = b >> 2;
            end
            return res;
        endfunction

        function bit [63:0] root_round(bit [63:0] s);
            bit [63:0] q;
            q = root_floor(s);
            if (s - q * q > q) q++;
            return q;
        endfunction

        // Vectoring rotation, angle in units of pi/2^31
        function longint arc(longint y, longint x);
            longint m, z, dx, dy;
            bit     flip;
            z = 0;
            if (y == 0) return (x >= 0) ? 0 : half_turn;
            if (x == 0) return (y > 0) ? half_turn / 2 : -(half_turn / 2);
            flip = x < 0;
            if (flip) begin
                x = -x;
                y = -y;
            end
            m = (x > (y < 0 ? -y : y)) ? x : (y < 0 ? -y : y);
            while (m < (longint'(1) << 40)) begin
                x = x * 2;
                y = y * 2;
                m = m * 2;
            end
            while (m >= (longint'(1) << 41)) begin
                x = x >>> 1;
                y = y >>> 1;
                m = m >>> 1;
            end
            for (int i = 0; i < ITERS; i++) begin
                dx = y >>> i;
                dy = x >>> i;
                if (y >= 0) begin
                    x += dx; y -= dy; z += arctan[i];
                end else begin
                    x -= dx; y += dy; z -= arctan[i];
                end
            end
            if (flip) begin
                z += half_turn;
                if (z > half_turn) z -= 2 * half_turn;
            end
            return z;
        endfunction

        function logic [AW-1:0] to_bam(longint a);
            longint v;
            v = (a + (longint'(1) << (31 - AW))) >>> (32 - AW);
            return v[AW-1:0];
        endfunction

        // Note an accepted target and queue its joint angles
        function void note_target(logic signed [CW-1:0] tx, ty, tz);
            longint     x, y, z, ax, ay, az, len, ul, d2, f, t, sum, dif;
            longint     n, two_ft, st, tib, alp, fem;
            t_joint_set e;
            x = tx; y = ty; z = tz;
            ax = x < 0 ? -x : x;
            ay = y < 0 ? -y : y;
            az = z < 0 ? -z : z;
            len = longint'(root_round(ax * ax + ay * ay)) - longint'(coxa_len);
            ul  = len < 0 ? -len : len;
            d2  = ul * ul + az * az;
            f = femur_len;
            t = tibia_len;
            sum = f + t;
            dif = f > t ? f - t : t - f;
            e.status = ST_OK;
            e.coxa   = to_bam(arc(y, x));
            e.femur  = '0;
            e.tibia  = '0;
            if (d2 >= sum * sum) begin
                e.status = ST_TOO_FAR;
            end else if (d2 <= dif * dif) begin
                e.status = ST_TOO_CLOSE;
            end else begin
                n      = d2 - f * f - t * t;
                two_ft = 2 * f * t;
                st     = longint'(root_round(64'(two_ft - n) * 64'(two_ft + n)));
                tib    = arc(st, n);
                alp    = arc(st, 2 * f * f + n);
                fem    = arc(z, len) - alp;
                if (fem < -half_turn || fem > half_turn) begin
                    e.status = ST_RANGE;
                end else begin
                    e.femur = to_bam(fem);
                    e.tibia = to_bam(tib);
                end
            end
            pending.push_back(e);
        endfunction

        // Compare one result strobe with the oldest pending set
        function void check_result(logic [1:0] st, logic [AW-1:0] cx, fm, tb);
            t_joint_set e;
            if (pending.size() == 0) begin
                $display("%0t: unexpected result status=%0d coxa=%h femur=%h tibia=%h",
                         $time, st, cx, fm, tb);
                errors++;
                return;
            end
            e = pending.pop_front();
            hits[e.status]++;
            if (st !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
            if (cx !== e.coxa) begin
                $display("%0t: coxa expected %h actual %h", $time, e.coxa, cx);
                errors++;
            end
            if (fm !== e.femur) begin
                $display("%0t: femur expected %h actual %h", $time, e.femur, fm);
                errors++;
            end
            if (tb !== e.tibia) begin
                $display("%0t: tibia expected %h actual %h", $time, e.tibia, tb);
                errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  start;
    logic                  busy;
    logic signed [CW-1:0]  i_target_x, i_target_y, i_target_z;
    logic                  i_cfg_we;
    logic [CFG_IDX_W-1:0]  i_cfg_idx;
    logic [CFG_W-1:0]      i_cfg_data;
    logic                  o_done;
    logic [1:0]            o_status;
    logic signed [AW-1:0]  o_coxa_out, o_femur_out, o_tibia_out;

    joint_scoreboard sb = new();
    int              targets_sent;
    int              idle_cycles;

    leg_inverse_kinematics #(
        .COORD_WIDTH      (CW),
        .ANGLE_WIDTH      (AW),
        .CORDIC_ITERATIONS(ITERS)
    ) i_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .start      (start),
        .busy       (busy),
        .i_target_x (i_target_x),
        .i_target_y (i_target_y),
        .i_target_z (i_target_z),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_done     (o_done),
        .o_status   (o_status),
        .o_coxa_out (o_coxa_out),
        .o_femur_out(o_femur_out),
        .o_tibia_out(o_tibia_out)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Check every result strobe
    always @(posedge i_clk) begin
        if (i_rst_n && o_done)
            sb.check_result(o_status, o_coxa_out, o_femur_out, o_tibia_out);
    end

    // Watchdog: end the run after too many cycles with no traffic
    always @(posedge i_clk) begin
        if (!i_rst_n || o_done || (start && !busy))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIM) begin
            $display("%0t: watchdog expired", $time);
            $display("leg_inverse_kinematics test failed");
            $finish;
        end
    end

    // Random idle length: mostly none or short, a few long
    function automatic int gap_len();
        int r;
        r = int'($urandom_range(0, 99));
        if (r < 55) return 0;
        if (r < 92) return int'($urandom_range(1, 4));
        return int'($urandom_range(10, 60));
    endfunction

    function automatic logic signed [CW-1:0] coord(int span);
        int v;
        v = int'($urandom_range(0, 2 * span)) - span;
        if (v > 32767) v = 32767;
        if (v < -32768) v = -32768;
        return v[CW-1:0];
    endfunction

    // Hold a target until accepted, then drop start for a random idle gap, if any
    task automatic send_target(logic signed [CW-1:0] x, y, z);
        int g;
        i_target_x = x;
        i_target_y = y;
        i_target_z = z;
        start      = 1'b1;
        while (busy) @(negedge i_clk);
        @(posedge i_clk);
        sb.note_target(x, y, z);
        targets_sent++;
        @(negedge i_clk);
        g = gap_len();
        if (g > 0) begin
            start = 1'b0;
            i_target_x = CW'($urandom);
            repeat (g - 1) @(negedge i_clk);
        end
    endtask

    // Drain the pipeline before touching the link lengths
    task automatic drain();
        start = 1'b0;
        while (sb.pending.size() != 0) @(negedge i_clk);
        repeat (LATENCY + 8) @(negedge i_clk);
    endtask

    task automatic write_len(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
        i_cfg_we   = 1'b1;
        i_cfg_idx  = idx;
        i_cfg_data = val;
        @(posedge i_clk);
        sb.set_len(idx, val);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
    endtask

    task automatic set_links(logic [CFG_W-1:0] c, f, t);
        write_len(REG_COXA_LEN, c);
        write_len(REG_FEMUR_LEN, f);
        write_len(REG_TIBIA_LEN, t);
    endtask

    // Random phase: mostly targets within the reach on each axis, some anywhere
    task automatic random_phase();
        int reach, r;
        reach = int'(sb.coxa_len) + int'(sb.femur_len) + int'(sb.tibia_len) + 64;
        for (int k = 0; k < PHASE_LEN; k++) begin
            r = int'($urandom_range(0, 9));
            if (r < 6)
                send_target(coord(reach), coord(reach), coord(reach));
            else if (r < 8)
                send_target(coord(reach / 8 + 4), coord(reach / 8 + 4), coord(reach / 4 + 4));
            else
                send_target(CW'($urandom), CW'($urandom), CW'($urandom));
        end
        drain();
    endtask

    initial begin
        int f, t, c;
        start      = 1'b0;
        i_target_x = '0;
        i_target_y = '0;
        i_target_z = '0;
        i_cfg_we   = 1'b0;
        i_cfg_idx  = REG_COXA_LEN;
        i_cfg_data = '0;
        i_rst_n    = 1'b0;
        targets_sent = 0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed targets at reset lengths: origin, axes, extremes, reach
        c = sb.coxa_len; f = sb.femur_len; t = sb.tibia_len;
        send_target(0, 0, 0);
        send_target(16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_target(-16'sd32768, -16'sd32768, -16'sd32768);
        send_target(-16'sd32768, 0, 0);
        send_target(-16'sd5000, 0, 16'sd2000);
        send_target(0, 16'sh7fff, 0);
        send_target(0, -16'sd32768, 0);
        send_target(16'(c + f + t), 0, 0);
        send_target(16'(c + f + t - 1), 0, 0);
        send_target(16'(c), 0, 0);
        send_target(16'(c), 0, 16'sd1);
        send_target(16'(c + 4000), 0, -16'sd8000);
        send_target(16'(c + 4000), 16'sd3000, 16'sd8000);
        send_target(-16'sd3000, -16'sd3000, -16'sd9000);
        send_target(16'sd1, -16'sd1, 16'sd1);
        send_target(16'sh5555, -16'sd21846, 16'sh2aaa);
        drain();

        random_phase();

        // Smallest links, no coxa
        set_links(15'd0, 15'd1, 15'd1);
        send_target(0, 0, 0);
        send_target(1, 0, 0);
        send_target(0, 0, 1);
        send_target(1, 1, 0);
        send_target(-1, 0, -1);
        send_target(0, 0, 2);
        drain();
        for (int k = 0; k < 60; k++)
            send_target(coord(3), coord(3), coord(3));
        drain();

        // Largest links
        set_links(15'h7fff, 15'h7fff, 15'h7fff);
        random_phase();

        // Very unequal links
        set_links(15'd200, 15'h7fff, 15'd1);
        random_phase();

        // Random lengths
        set_links(CFG_W'($urandom_range(0, 32767)), CFG_W'($urandom_range(1, 16000)),
                  CFG_W'($urandom_range(1, 16000)));
        random_phase();
        set_links(CFG_W'($urandom_range(0, 4000)), CFG_W'($urandom_range(1, 4000)),
                  CFG_W'($urandom_range(1, 4000)));
        random_phase();

        $display("%0d targets sent over six link settings", targets_sent);
        $display("status counts: ok %0d, too far %0d, too close %0d, range %0d",
                 sb.hits[ST_OK], sb.hits[ST_TOO_FAR], sb.hits[ST_TOO_CLOSE],
                 sb.hits[ST_RANGE]);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("leg_inverse_kinematics test passed");
        else
            $display("leg_inverse_kinematics test failed");
        $finish;
    end

endmodule
